FILE: rtl/core/luhn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luhn classifier package
// Widths, brand codes, the scan result type and the brand classification
// shared by the modules of the Luhn card classifier.
// ----------------------------------------------------------------------------
package luhn_pkg;

  localparam int CardW   = 64;
  localparam int DigitN  = 20;
  localparam int DigitW  = 4;
  localparam int BcdW    = DigitN * DigitW;
  localparam int CountW  = 5;
  localparam int BrandW  = 2;

  localparam logic [CountW-1:0] AmexLen    = 5'd15;
  localparam logic [CountW-1:0] MasterLen  = 5'd16;
  localparam logic [CountW-1:0] VisaShort  = 5'd13;
  localparam logic [CountW-1:0] VisaLong   = 5'd16;
  localparam logic [CountW-1:0] MinLen     = 5'd2;

  typedef enum logic [BrandW-1:0] {
    BRAND_INVALID    = 2'd0,
    BRAND_AMEX       = 2'd1,
    BRAND_MASTERCARD = 2'd2,
    BRAND_VISA       = 2'd3
  } brand_t;

  typedef struct packed {
    brand_t              brand;
    logic                checksum_ok;
    logic [CountW-1:0]   digit_count;
  } luhn_res_t;

  // Brand from the digit count and the two leading decimal digits.
  function automatic brand_t classify(input logic [CountW-1:0] cnt,
                                      input logic [DigitW-1:0] hi,
                                      input logic [DigitW-1:0] lo);
    brand_t b;
    b = BRAND_INVALID;
    if (cnt == AmexLen && hi == 4'd3 && (lo == 4'd4 || lo == 4'd7)) begin
      b = BRAND_AMEX;
    end else if (cnt == MasterLen && hi == 4'd5 && lo inside {[4'd1:4'd5]}) begin
      b = BRAND_MASTERCARD;
    end else if ((cnt == VisaShort || cnt == VisaLong) && hi == 4'd4) begin
      b = BRAND_VISA;
    end
    return b;
  endfunction

endpackage

FILE: rtl/core/luhn_card_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luhn card classifier
// Checks a binary card number with the Luhn mod-10 rule and names its brand.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one card number per beat (in_card_number). The
// result channel carries brand, checksum flag and decimal digit count per
// beat. Each channel hands over a beat when valid is high and stall is low.
// An accepted number first runs through a 64-step binary-to-BCD shift
// converter, one bit a cycle, and then through a 20-step digit scan, one
// decimal digit a cycle. The two passes run one after the other, and a new
// number is taken only once the result of the previous one has been loaded
// into the output register.
// in_stall is high while a number is being worked on. The result sits in an
// output register, so a new number is accepted while a finished result is
// still held by a stalled receiver; a second result then waits in the scan
// unit until the output register frees up.
// Reset clears the sequencer and the output valid; no clearing pass is run.
// ----------------------------------------------------------------------------
module luhn_card_classifier_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [luhn_pkg::CardW-1:0]   in_card_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [luhn_pkg::BrandW-1:0]  out_brand,
  output logic                         out_checksum_ok,
  output logic [luhn_pkg::CountW-1:0]  out_digit_count
);
  import luhn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  luhn_res_t         out_res_r, out_res_nxt;

  logic              in_acc;
  logic              out_free;
  logic              load;
  logic              conv_done;
  logic [BcdW-1:0]   bcd;
  logic              scan_done;
  luhn_res_t         scan_res;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load     = (state_r == S_HOLD) && out_free;

  luhn_b2bcd u_b2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .bin   (in_card_number),
    .done  (conv_done),
    .bcd   (bcd)
  );

  luhn_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_done),
    .bcd   (bcd),
    .done  (scan_done),
    .res   (scan_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_CONV;
      S_CONV: if (conv_done) state_nxt = S_SCAN;
      S_SCAN: if (scan_done) state_nxt = S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = scan_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_brand       = out_res_r.brand;
  assign out_checksum_ok = out_res_r.checksum_ok;
  assign out_digit_count = out_res_r.digit_count;

endmodule

FILE: rtl/core/luhn_b2bcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-3 conversion of the 64-bit card number into twenty decimal
// digits, one input bit per cycle.
// ----------------------------------------------------------------------------
module luhn_b2bcd (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [luhn_pkg::CardW-1:0]  bin,
  output logic                        done,
  output logic [luhn_pkg::BcdW-1:0]   bcd
);
  import luhn_pkg::*;

  localparam int CntW = $clog2(CardW + 1);

  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [CardW-1:0] sh_r, sh_nxt;
  logic [BcdW-1:0]  bcd_r, bcd_nxt;
  logic [BcdW-1:0]  adj;
  logic             done_r, done_nxt;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < DigitN; i++) begin
      adj[i*DigitW +: DigitW] = (bcd_r[i*DigitW +: DigitW] >= 4'd5) ?
                                bcd_r[i*DigitW +: DigitW] + 4'd3 :
                                bcd_r[i*DigitW +: DigitW];
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = bin;
      bcd_nxt = '0;
      cnt_nxt = CntW'(CardW);
    end else if (cnt_r != '0) begin
      {bcd_nxt, sh_nxt} = {adj, sh_r} << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

FILE: rtl/core/luhn_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luhn digit scan
// Walks the decimal digits from the right, one a cycle, forming the Luhn sum
// modulo ten, the digit count and the two leading digits.
// ----------------------------------------------------------------------------
module luhn_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [luhn_pkg::BcdW-1:0]  bcd,
  output logic                       done,
  output luhn_pkg::luhn_res_t        res
);
  import luhn_pkg::*;

  localparam logic [CountW-1:0] LastIdx = CountW'(DigitN - 1);

  logic [BcdW-1:0]   sh_r, sh_nxt;
  logic [CountW-1:0] idx_r, idx_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [DigitW-1:0] sum_r, sum_nxt;
  logic [DigitW-1:0] hi_r, hi_nxt;
  logic [DigitW-1:0] lo_r, lo_nxt;
  logic [DigitW-1:0] prev_r, prev_nxt;
  logic              active_r, active_nxt;
  logic              done_r, done_nxt;

  logic [DigitW-1:0] d;
  logic [DigitW:0]   dbl;
  logic [DigitW:0]   dbl_adj;
  logic [DigitW-1:0] term;
  logic [DigitW:0]   s5;
  logic              ok;

  assign d       = sh_r[DigitW-1:0];
  assign dbl     = {d, 1'b0};
  assign dbl_adj = (dbl > 5'd9) ? dbl - 5'd9 : dbl;
  assign term    = idx_r[0] ? dbl_adj[DigitW-1:0] : d;
  assign s5      = {1'b0, sum_r} + {1'b0, term};

  always_comb begin
    sh_nxt     = sh_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    prev_nxt   = prev_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      sh_nxt     = bcd;
      idx_nxt    = '0;
      cnt_nxt    = '0;
      sum_nxt    = '0;
      hi_nxt     = '0;
      lo_nxt     = '0;
      prev_nxt   = '0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      sh_nxt   = sh_r >> DigitW;
      idx_nxt  = idx_r + 1'b1;
      sum_nxt  = (s5 >= 5'd10) ? DigitW'(s5 - 5'd10) : s5[DigitW-1:0];
      prev_nxt = d;
      // The most significant non-zero digit seen so far sets the count.
      if (d != '0) begin
        cnt_nxt = idx_r + 1'b1;
        hi_nxt  = d;
        lo_nxt  = prev_r;
      end
      if (idx_r == LastIdx) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    prev_r <= prev_nxt;
  end

  assign ok              = (cnt_r != '0) && (sum_r == '0);
  assign res.checksum_ok = ok;
  assign res.digit_count = cnt_r;
  assign res.brand       = (ok && cnt_r >= MinLen) ? classify(cnt_r, hi_r, lo_r)
                                                    : BRAND_INVALID;
  assign done            = done_r;

endmodule

FILE: rtl/core/luhn_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Luhn classifier port checker
// Checks the results and handshakes seen on the classifier's ports.
// ----------------------------------------------------------------------------
module luhn_chk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [luhn_pkg::BrandW-1:0]  out_brand,
  input  logic                         out_checksum_ok,
  input  logic [luhn_pkg::CountW-1:0]  out_digit_count
);
  import luhn_pkg::*;

  // A held result beat must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_brand) &&
    $stable(out_checksum_ok) && $stable(out_digit_count))
    else $error("result beat changed while stalled");

  // Once a number is taken the block is busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking a number");

  // A brand is only ever named for a number with a good checksum.
  a_brand_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brand != BRAND_INVALID |-> out_checksum_ok)
    else $error("brand reported with a bad checksum");

  // Each brand has its own permitted lengths.
  a_brand_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_brand != BRAND_AMEX || out_digit_count == AmexLen) &&
      (out_brand != BRAND_MASTERCARD || out_digit_count == MasterLen) &&
      (out_brand != BRAND_VISA || out_digit_count == VisaShort ||
       out_digit_count == VisaLong))
    else $error("brand reported with a wrong digit count");

  // A zero card number has no digits and never passes the checksum.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digit_count == '0 |-> !out_checksum_ok)
    else $error("empty number reported as passing");

endmodule

bind luhn_card_classifier_core luhn_chk u_luhn_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_brand       (out_brand),
  .out_checksum_ok (out_checksum_ok),
  .out_digit_count (out_digit_count)
);
